// ===== design/vector3_normalize_defines.svh =====
// assertion macros for the vector3_normalize checker
// no dependencies; expects clk and rst_n in the scope where they are used
`ifndef VECTOR3_NORMALIZE_DEFINES_SVH
`define VECTOR3_NORMALIZE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define VN_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define VN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/vn_pkg.sv =====
// shared types for the vector3_normalize block
// no dependencies
`default_nettype none

package vn_pkg;

  typedef struct packed {
    logic valid;
    logic zero;
  } vn_ctrl_t;

endpackage

`default_nettype wire

// ===== design/vn_isqrt.sv =====
// pipelined integer square root, one root bit per stage
// no package dependencies
`default_nettype none

module vn_isqrt #(
  parameter int W = 16
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [2*W-1:0] sum_i,
  output logic      [W-1:0]   root_o
);

  localparam int RW = W + 3;

  logic [RW-1:0]  rem_r  [W];
  logic [W-1:0]   root_r [W];
  logic [2*W-1:0] n_r    [W];

  genvar i;
  generate
    for (i = 0; i < W; i++) begin : g_stage
      logic [RW-1:0]  rem_in;
      logic [RW-1:0]  cur;
      logic [RW-1:0]  trial;
      logic [W-1:0]   root_in;
      logic [2*W-1:0] n_in;

      if (i == 0) begin : g_first
        assign rem_in  = '0;
        assign root_in = '0;
        assign n_in    = sum_i;
      end else begin : g_next
        assign rem_in  = rem_r[i-1];
        assign root_in = root_r[i-1];
        assign n_in    = n_r[i-1];
      end

      assign cur   = {rem_in[RW-3:0], n_in[2*(W-1-i)+1 -: 2]};
      assign trial = {1'b0, root_in, 2'b01};

      always_ff @(posedge clk) begin
        if (en) begin
          if (cur >= trial) begin
            rem_r[i]  <= cur - trial;
            root_r[i] <= {root_in[W-2:0], 1'b1};
          end else begin
            rem_r[i]  <= cur;
            root_r[i] <= {root_in[W-2:0], 1'b0};
          end
          n_r[i] <= n_in;
        end
      end
    end
  endgenerate

  assign root_o = root_r[W-1];

endmodule

`default_nettype wire

// ===== design/vn_div_lane.sv =====
// one divider lane: pipelined restoring division of a * 2^F by the magnitude
// relies on a <= magnitude, so the quotient fits F+1 bits; no package use
`default_nettype none

module vn_div_lane #(
  parameter int W = 16,
  parameter int F = 15
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] a_i,
  input  wire logic [W-1:0] mag_i,
  input  wire logic         neg_i,
  output logic      [F:0]   q_o,
  output logic              neg_o
);

  logic [W:0]   rem_r [F+1];
  logic [W-1:0] mag_r [F+1];
  logic [F:0]   q_r   [F+1];
  logic         neg_r [F+1];

  genvar j;
  generate
    for (j = 0; j <= F; j++) begin : g_stage
      logic [W:0]   rem_in;
      logic [W:0]   diff;
      logic [W-1:0] mag_in;
      logic [F:0]   q_in;
      logic         neg_in;
      logic         take;

      if (j == 0) begin : g_first
        assign rem_in = {1'b0, a_i};
        assign mag_in = mag_i;
        assign q_in   = '0;
        assign neg_in = neg_i;
      end else begin : g_next
        assign rem_in = rem_r[j-1];
        assign mag_in = mag_r[j-1];
        assign q_in   = q_r[j-1];
        assign neg_in = neg_r[j-1];
      end

      assign take = rem_in >= {1'b0, mag_in};
      assign diff = take ? (rem_in - {1'b0, mag_in}) : rem_in;

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= {diff[W-1:0], 1'b0};
          mag_r[j] <= mag_in;
          q_r[j]   <= {q_in[F-1:0], take};
          neg_r[j] <= neg_in;
        end
      end
    end
  endgenerate

  assign q_o   = q_r[F];
  assign neg_o = neg_r[F];

endmodule

`default_nettype wire

// ===== design/vn_merge.sv =====
// merge stage: saturates and signs the three lane quotients, output register
// depends on vn_pkg for the control struct
`default_nettype none

module vn_merge #(
  parameter int F = 15
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire vn_pkg::vn_ctrl_t   ctrl_i,
  input  wire logic [2:0][F:0]    q_i,
  input  wire logic [2:0]         neg_i,
  output logic                    valid_o,
  output logic [2:0][F:0]         unit_o,
  output logic                    zero_o,
  output logic                    sat_o
);

  import vn_pkg::*;

  logic            valid_r;
  logic [2:0][F:0] unit_r;
  logic [2:0][F:0] unit_nxt;
  logic            zero_r;
  logic            sat_r;
  logic            sat_nxt;

  always_comb begin
    logic [F-1:0] clip;
    logic [F:0]   pos;
    sat_nxt  = 1'b0;
    unit_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      clip = q_i[k][F] ? {F{1'b1}} : q_i[k][F-1:0];
      pos  = {1'b0, clip};
      unit_nxt[k] = neg_i[k] ? (~pos + 1'b1) : pos;
      sat_nxt = sat_nxt | q_i[k][F];
    end
    if (ctrl_i.zero) begin
      unit_nxt = '0;
      sat_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit_r <= unit_nxt;
      zero_r <= ctrl_i.zero;
      sat_r  <= sat_nxt;
    end
  end

  assign valid_o = valid_r;
  assign unit_o  = unit_r;
  assign zero_o  = zero_r;
  assign sat_o   = sat_r;

endmodule

`default_nettype wire

// ===== design/vector3_normalize.sv =====
// top level of the 3-component vector normalizer
// depends on vn_pkg, vn_isqrt, vn_div_lane and vn_merge
//
//   channel | ports                                                               | dir
//   --------+---------------------------------------------------------------------+----
//   input   | in_valid, in_stall, in_x_in, in_y_in, in_z_in                       | in
//   result  | out_valid, out_stall, out_x/y/z_unit, out_zero_vector, out_saturated | out
//
// one transaction per cycle unless out_stall holds a result; the path runs
// through the input register (magnitudes and squares), the sum register, the
// root stages (one bit each), the divider lanes (one quotient bit each) and
// the merge register; the whole pipeline holds while a result waits under
// out_stall, and in_stall follows that; synchronous reset clears the valid bits only
`default_nettype none

module vector3_normalize #(
  parameter int IN_WIDTH      = 16,
  parameter int OUT_FRAC_BITS = 15
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic signed [IN_WIDTH-1:0]      in_x_in,
  input  wire logic signed [IN_WIDTH-1:0]      in_y_in,
  input  wire logic signed [IN_WIDTH-1:0]      in_z_in,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [OUT_FRAC_BITS:0]        out_x_unit,
  output logic signed [OUT_FRAC_BITS:0]        out_y_unit,
  output logic signed [OUT_FRAC_BITS:0]        out_z_unit,
  output logic                                 out_zero_vector,
  output logic                                 out_saturated
);

  import vn_pkg::*;

  localparam int W = IN_WIDTH;
  localparam int F = OUT_FRAC_BITS;
  localparam int L = W + F + 3;

  logic                    en;
  logic [2:0][W-1:0]       comp;
  logic [2:0][W-1:0]       a_nxt;
  logic [2:0]              neg_nxt;
  logic [2:0][W-1:0]       a_s0_r;
  logic [2:0]              neg_s0_r;
  logic [2:0][2*W-1:0]     sq_r;
  logic [2*W-1:0]          sum_r;
  logic [2:0][W-1:0]       a_dly_r   [W+1];
  logic [2:0]              neg_dly_r [W+1];
  logic [L-1:0]            v_r;
  logic [F:0]              zero_dly_r;
  logic [W-1:0]            root;
  logic [2:0][F:0]         q;
  logic [2:0]              q_neg;
  vn_ctrl_t                ctrl;
  logic [2:0][F:0]         unit;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign comp[0] = in_x_in;
  assign comp[1] = in_y_in;
  assign comp[2] = in_z_in;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      neg_nxt[k] = comp[k][W-1];
      a_nxt[k]   = comp[k][W-1] ? (~comp[k] + 1'b1) : comp[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_s0_r   <= a_nxt;
      neg_s0_r <= neg_nxt;
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= a_nxt[k] * a_nxt[k];
      end
      sum_r        <= sq_r[0] + sq_r[1] + sq_r[2];
      a_dly_r[0]   <= a_s0_r;
      neg_dly_r[0] <= neg_s0_r;
      for (int d = 1; d <= W; d++) begin
        a_dly_r[d]   <= a_dly_r[d-1];
        neg_dly_r[d] <= neg_dly_r[d-1];
      end
      zero_dly_r <= {zero_dly_r[F-1:0], (root == '0)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[L-2:0], in_valid};
    end
  end

  vn_isqrt #(.W(W)) u_isqrt (
    .clk    (clk),
    .en     (en),
    .sum_i  (sum_r),
    .root_o (root)
  );

  genvar k;
  generate
    for (k = 0; k < 3; k++) begin : g_lane
      vn_div_lane #(.W(W), .F(F)) u_lane (
        .clk   (clk),
        .en    (en),
        .a_i   (a_dly_r[W][k]),
        .mag_i (root),
        .neg_i (neg_dly_r[W][k]),
        .q_o   (q[k]),
        .neg_o (q_neg[k])
      );
    end
  endgenerate

  assign ctrl.valid = v_r[L-1];
  assign ctrl.zero  = zero_dly_r[F];

  vn_merge #(.F(F)) u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctrl_i  (ctrl),
    .q_i     (q),
    .neg_i   (q_neg),
    .valid_o (out_valid),
    .unit_o  (unit),
    .zero_o  (out_zero_vector),
    .sat_o   (out_saturated)
  );

  assign out_x_unit = unit[0];
  assign out_y_unit = unit[1];
  assign out_z_unit = unit[2];

endmodule

`default_nettype wire

// ===== design/vn_checker.sv =====
// port-level checker for vector3_normalize, bound to the top level
// depends on vector3_normalize_defines.svh
`default_nettype none

`include "vector3_normalize_defines.svh"

module vn_checker #(
  parameter int OUT_FRAC_BITS = 15
) (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic signed [OUT_FRAC_BITS:0]   out_x_unit,
  input wire logic signed [OUT_FRAC_BITS:0]   out_y_unit,
  input wire logic signed [OUT_FRAC_BITS:0]   out_z_unit,
  input wire logic                            out_zero_vector,
  input wire logic                            out_saturated
);

  localparam int F = OUT_FRAC_BITS;

  logic [F:0] lim_p;
  logic [F:0] lim_n;
  logic       any_lim;
  logic       any_min;
  logic       unit_zero;

  assign lim_p = {1'b0, {F{1'b1}}};
  assign lim_n = {1'b1, {(F-1){1'b0}}, 1'b1};
  assign any_lim = (out_x_unit == lim_p) || (out_x_unit == lim_n) ||
                   (out_y_unit == lim_p) || (out_y_unit == lim_n) ||
                   (out_z_unit == lim_p) || (out_z_unit == lim_n);
  assign any_min = (out_x_unit == {1'b1, {F{1'b0}}}) ||
                   (out_y_unit == {1'b1, {F{1'b0}}}) ||
                   (out_z_unit == {1'b1, {F{1'b0}}});
  assign unit_zero = (out_x_unit == '0) && (out_y_unit == '0) && (out_z_unit == '0);

  `VN_ASSERT_IMPLY(a_zero_clean, out_valid && out_zero_vector, unit_zero && !out_saturated, "zero vector nonzero")
  `VN_ASSERT_IMPLY(a_sat_at_limit, out_valid && out_saturated, any_lim, "saturated without clip")
  `VN_ASSERT_IMPLY(a_no_min_code, out_valid, !any_min, "component below negative limit")
  `VN_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `VN_ASSERT_IMPLY(a_stall_follows, in_valid && in_stall, out_valid && out_stall, "stray input stall")

endmodule

bind vector3_normalize vn_checker #(
  .OUT_FRAC_BITS (OUT_FRAC_BITS)
) u_vn_checker (.*);

`default_nettype wire
